@@ rtl/bphd_pkg.sv @@
// ----------------------------------------------------------------------------
// bphd_pkg
// Shared constants for the band peak hold / decay block.
// ----------------------------------------------------------------------------
package bphd_pkg;

    localparam int BANDS       = 7;
    localparam int LVL_W       = 10;
    localparam int BAND_W      = 3;
    localparam int IDX_W       = $clog2(BANDS + 1);
    localparam int CFG_W       = 8;
    localparam int ELAPSED_W   = 8;

    // Decay: level * rolloff / 200 = ((level * rolloff) >> 3) / 25
    // and x / 25 = (x * 5243) >> 17, exact for x below 2^15.
    localparam int MUL_A_W     = 15;
    localparam int MUL_B_W     = 13;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int PRE_SHIFT   = 3;
    localparam int DIV_SHIFT   = 17;
    localparam int QUO_W       = PROD_W - DIV_SHIFT;
    localparam logic [MUL_B_W-1:0] RECIP = 13'd5243;

    localparam logic [LVL_W-1:0]     LVL_MAX         = '1;
    localparam logic [CFG_W-1:0]     ROLLOFF_RST     = 8'd180;
    localparam logic [CFG_W-1:0]     PERIOD_RST      = 8'd5;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = '1;

    // configuration register indexes
    localparam logic CFG_ROLLOFF = 1'b0;
    localparam logic CFG_PERIOD  = 1'b1;

    // item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

endpackage

@@ rtl/bphd_mul.sv @@
// ----------------------------------------------------------------------------
// bphd_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module bphd_mul (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [bphd_pkg::MUL_A_W-1:0] i_a,
    input  logic [bphd_pkg::MUL_B_W-1:0] i_b,
    output logic [bphd_pkg::PROD_W-1:0]  o_p
);

    logic [bphd_pkg::PROD_W-1:0] r_p;

    // product holds while i_en is low
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= bphd_pkg::PROD_W'(i_a) * bphd_pkg::PROD_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

@@ rtl/band_peak_hold_decay_top.sv @@
// ----------------------------------------------------------------------------
// band_peak_hold_decay_top
// Per-band running peak, shown level with decay, all-time maxima, and volume.
//
//  channel  dir  tdata (low bit up)                          tuser      tlast
//  s_*      in   band[3] amp_first[10] amp_second[10]        opcode[1]  -
//                vol_first[10] vol_second[10] pad[5]
//  m_*      out  band_index[3] level[10] peak_max[10] pad[1] is_volume  last
//  cfg      in   idx 0 rolloff, idx 1 collect_period, data[8]
//
// A sample item or a tick without collect leaves the block in S_IDLE, ready for the next item.
// A collecting tick walks BANDS+1 entries, each through S_MUL1, S_MUL2 and
// S_SETTLE on the one shared multiplier; S_SETTLE waits on any output stall.
// Input is not ready while a collect runs. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module band_peak_hold_decay_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // band[2:0], amp_first[12:3], amp_second[22:13], vol_first[32:23],
    // vol_second[42:33], zero pad[47:43]
    input  logic [47:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,   // opcode[0]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // band_index[2:0], level[12:3], peak_max[22:13], zero pad[23]
    output logic [23:0] o_m_tdata,
    output logic [0:0]  o_m_tuser,   // is_volume[0]
    output logic        o_m_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    localparam int BANDS = bphd_pkg::BANDS;
    localparam int LVL_W = bphd_pkg::LVL_W;
    localparam int IDX_W = bphd_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MUL1   = 4'b0010,
        S_MUL2   = 4'b0100,
        S_SETTLE = 4'b1000
    } t_state;

    t_state r_state;

    logic [LVL_W-1:0] r_band_peak  [BANDS];
    logic [LVL_W-1:0] r_band_shown [BANDS];
    logic [LVL_W-1:0] r_band_max   [BANDS];
    logic [LVL_W-1:0] r_vol_peak;
    logic [LVL_W-1:0] r_vol_shown;
    logic [LVL_W-1:0] r_vol_max;
    logic [bphd_pkg::ELAPSED_W-1:0] r_elapsed;
    logic [bphd_pkg::CFG_W-1:0]     r_rolloff;
    logic [bphd_pkg::CFG_W-1:0]     r_period;
    logic [IDX_W-1:0]               r_idx;

    logic                            r_m_valid;
    logic [bphd_pkg::BAND_W-1:0]     r_m_band;
    logic [LVL_W-1:0]                r_m_level;
    logic [LVL_W-1:0]                r_m_max;
    logic                            r_m_vol;

    // input unpack
    logic                        s_op;
    logic [bphd_pkg::BAND_W-1:0] s_band;
    logic [LVL_W-1:0]            s_amp_a, s_amp_b, s_vol_a, s_vol_b;
    logic [LVL_W:0]              amp_sum, vol_sum;
    logic [LVL_W-1:0]            amp_avg, vol_avg;

    assign s_op    = i_s_tuser[0];
    assign s_band  = i_s_tdata[2:0];
    assign s_amp_a = i_s_tdata[12:3];
    assign s_amp_b = i_s_tdata[22:13];
    assign s_vol_a = i_s_tdata[32:23];
    assign s_vol_b = i_s_tdata[42:33];
    assign amp_sum = {1'b0, s_amp_a} + {1'b0, s_amp_b};
    assign vol_sum = {1'b0, s_vol_a} + {1'b0, s_vol_b};
    assign amp_avg = amp_sum[LVL_W:1];
    assign vol_avg = vol_sum[LVL_W:1];

    logic s_fire;
    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;

    // tick counter
    logic [bphd_pkg::ELAPSED_W-1:0] n_elapsed;
    logic                           collect;
    always_comb begin
        n_elapsed = (r_elapsed == bphd_pkg::ELAPSED_MAX) ? r_elapsed
                  : r_elapsed + bphd_pkg::ELAPSED_W'(1);
        collect   = n_elapsed > r_period;
    end

    // current collect entry
    logic                        cur_vol;
    logic [bphd_pkg::BAND_W-1:0] cur_band;
    logic [LVL_W-1:0]            cur_peak, cur_shown, cur_max;
    assign cur_vol  = (r_idx == IDX_W'(BANDS));
    assign cur_band = r_idx[bphd_pkg::BAND_W-1:0];

    always_comb begin
        if (cur_vol) begin
            cur_peak  = r_vol_peak;
            cur_shown = r_vol_shown;
            cur_max   = r_vol_max;
        end else begin
            cur_peak  = r_band_peak[cur_band];
            cur_shown = r_band_shown[cur_band];
            cur_max   = r_band_max[cur_band];
        end
    end

    // shared multiplier
    logic [bphd_pkg::MUL_A_W-1:0] mul_a;
    logic [bphd_pkg::MUL_B_W-1:0] mul_b;
    logic [bphd_pkg::PROD_W-1:0]  mul_p;
    logic                         mul_en;

    assign mul_en = (r_state == S_MUL1) || (r_state == S_MUL2);

    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = bphd_pkg::MUL_A_W'(cur_shown);
            mul_b = bphd_pkg::MUL_B_W'(r_rolloff);
        end else begin
            mul_a = mul_p[bphd_pkg::PRE_SHIFT +: bphd_pkg::MUL_A_W];
            mul_b = bphd_pkg::RECIP;
        end
    end

    bphd_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // settle
    logic [bphd_pkg::QUO_W-1:0] quo;
    logic [LVL_W-1:0]           decayed, n_shown, n_max;
    logic                       out_free;
    logic                       m_load;

    always_comb begin
        quo     = mul_p[bphd_pkg::DIV_SHIFT +: bphd_pkg::QUO_W];
        decayed = (quo > bphd_pkg::QUO_W'(bphd_pkg::LVL_MAX)) ? bphd_pkg::LVL_MAX
                : quo[LVL_W-1:0];
        n_shown = (cur_peak > cur_shown) ? cur_peak : decayed;
        n_max   = (cur_peak > cur_max) ? cur_peak : cur_max;
    end

    assign out_free = !r_m_valid || i_m_tready;
    assign m_load   = (r_state == S_SETTLE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_elapsed   <= '0;
            r_rolloff   <= bphd_pkg::ROLLOFF_RST;
            r_period    <= bphd_pkg::PERIOD_RST;
            r_m_valid   <= 1'b0;
            r_vol_peak  <= '0;
            r_vol_shown <= '0;
            r_vol_max   <= '0;
            for (int i = 0; i < BANDS; i++) begin
                r_band_peak[i]  <= '0;
                r_band_shown[i] <= '0;
                r_band_max[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bphd_pkg::CFG_ROLLOFF: r_rolloff <= i_cfg_data;
                    bphd_pkg::CFG_PERIOD:  r_period  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (m_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        if (s_op == bphd_pkg::OP_SAMPLE) begin
                            if (vol_avg > r_vol_peak) begin
                                r_vol_peak <= vol_avg;
                            end
                            if ((32'(s_band) < BANDS) && (amp_avg > r_band_peak[s_band])) begin
                                r_band_peak[s_band] <= amp_avg;
                            end
                        end else if (collect) begin
                            r_elapsed <= '0;
                            r_idx     <= '0;
                            r_state   <= S_MUL1;
                        end else begin
                            r_elapsed <= n_elapsed;
                        end
                    end
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_SETTLE;
                end
                S_SETTLE: begin
                    if (out_free) begin
                        r_m_level <= n_shown;
                        r_m_max   <= n_max;
                        r_m_vol   <= cur_vol;
                        if (cur_vol) begin
                            r_m_band    <= '0;
                            r_vol_shown <= n_shown;
                            r_vol_max   <= n_max;
                            r_vol_peak  <= '0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_m_band               <= cur_band;
                            r_band_shown[cur_band] <= n_shown;
                            r_band_max[cur_band]   <= n_max;
                            r_band_peak[cur_band]  <= '0;
                            r_idx                  <= r_idx + IDX_W'(1);
                            r_state                <= S_MUL1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_max, r_m_level, r_m_band};
    assign o_m_tuser  = r_m_vol;
    assign o_m_tlast  = r_m_vol;

endmodule
